// File: rtl/ssed_pkg.sv
// ----------------------------------------------------------------------------
// ssed_pkg: shared types and constants of the slow start exit detector
// Item, result and configuration records, mode and status codes, and the
// register indexes of the configuration port.
// ----------------------------------------------------------------------------
package ssed_pkg;

  // Threshold is the last round minimum divided by 2**RTT_DIVISOR_SHIFT, before clamping
  localparam int unsigned RTT_DIVISOR_SHIFT = 3;

  localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;
  localparam logic [7:0]  ALL8  = 8'hFF;

  // Stream widths (payload padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 312;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CSS_ROUNDS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLE = 2'd3;

  // Configuration reset values
  localparam logic [31:0] MIN_DELAY_RST  = 32'd4000000;
  localparam logic [31:0] MAX_DELAY_RST  = 32'd16000000;
  localparam logic [7:0]  CSS_ROUNDS_RST = 8'd5;
  localparam logic [7:0]  MIN_SAMPLE_RST = 8'd8;

  typedef enum logic [1:0] {
    MODE_ACK     = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_DISABLE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_REJECT = 2'd0,
    STAT_SAME   = 2'd1,
    STAT_CHANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] min_delay_threshold_ns;
    logic [31:0] max_delay_threshold_ns;
    logic [7:0]  css_round_limit;
    logic [7:0]  min_rtt_samples;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] delivered_bytes;
    logic [63:0] bytes_in_flight;
    logic [63:0] rtt_sample_ns;
    logic        rtt_valid;
    logic [39:0] cwnd;
    logic [39:0] ssthresh;
    logic [15:0] link_mss;
    logic [15:0] model_mss;
    logic        time_nonzero;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        ack_in_css;
    logic        css_active;
    logic        exit_pending;
    logic [7:0]  css_round_count;
    logic [31:0] css_enter_count;
    logic [31:0] css_revert_count;
  } result_t;

endpackage

// File: rtl/ssed_cfg.sv
// ----------------------------------------------------------------------------
// ssed_cfg: configuration register file
// Holds the delay clamps, the CSS round limit and the sample minimum, written
// one register per request over the configuration channel.
// ----------------------------------------------------------------------------
module ssed_cfg
  import ssed_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Always able to take a write
  assign cfg_ready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_delay_threshold_ns <= MIN_DELAY_RST;
      cfg.max_delay_threshold_ns <= MAX_DELAY_RST;
      cfg.css_round_limit        <= CSS_ROUNDS_RST;
      cfg.min_rtt_samples        <= MIN_SAMPLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_DELAY:  cfg.min_delay_threshold_ns <= cfg_data;
        CFG_MAX_DELAY:  cfg.max_delay_threshold_ns <= cfg_data;
        CFG_CSS_ROUNDS: cfg.css_round_limit        <= cfg_data[7:0];
        CFG_MIN_SAMPLE: cfg.min_rtt_samples        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/ssed_core.sv
// ----------------------------------------------------------------------------
// ssed_core: detector state and per-item update
// Holds the round tracking, RTT minimums and phase flags. Computes the next
// state and the result of the registered item in one pass; state commits
// when step is high.
// ----------------------------------------------------------------------------
module ssed_core
  import ssed_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [63:0] last_round_min_rtt, last_round_min_rtt_next;
  logic [63:0] current_round_min_rtt, current_round_min_rtt_next;
  logic [63:0] css_baseline_rtt, css_baseline_rtt_next;
  logic [63:0] round_end_delivered, round_end_delivered_next;
  logic [31:0] round_sample_count, round_sample_count_next;
  logic [7:0]  css_rounds_done, css_rounds_done_next;
  logic [31:0] enter_events, enter_events_next;
  logic [31:0] revert_events, revert_events_next;
  logic        detector_enabled, detector_enabled_next;
  logic        in_css, in_css_next;
  logic        arrival_css, arrival_css_next;
  logic        exit_flag, exit_flag_next;
  logic        initial_done, initial_done_next;
  status_t     status;
  logic        is_reject;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[64] ? ALL64 : sum[63:0];
  endfunction

  assign is_reject = !item.time_nonzero || (item.link_mss == 16'd0);

  // Compute next state and status for the current item
  always_comb begin : step_logic
    logic        halted;
    logic        start_round;
    logic [7:0]  rounds_inc;
    logic [63:0] cur_new;
    logic [31:0] cnt_new;
    logic        enough;
    logic [63:0] thr_raw;
    logic [31:0] thr;

    last_round_min_rtt_next    = last_round_min_rtt;
    current_round_min_rtt_next = current_round_min_rtt;
    css_baseline_rtt_next      = css_baseline_rtt;
    round_end_delivered_next   = round_end_delivered;
    round_sample_count_next    = round_sample_count;
    css_rounds_done_next       = css_rounds_done;
    enter_events_next          = enter_events;
    revert_events_next         = revert_events;
    detector_enabled_next      = detector_enabled;
    in_css_next                = in_css;
    arrival_css_next           = arrival_css;
    exit_flag_next             = exit_flag;
    initial_done_next          = initial_done;
    status                     = STAT_SAME;

    halted      = 1'b0;
    start_round = (round_end_delivered == 64'd0) ||
                  ((item.delivered_bytes != 64'd0) &&
                   (item.delivered_bytes >= round_end_delivered));
    rounds_inc  = (css_rounds_done == ALL8) ? css_rounds_done : css_rounds_done + 8'd1;
    cur_new     = ALL64;
    cnt_new     = 32'd0;
    enough      = 1'b0;
    thr_raw     = 64'd0;
    thr         = 32'd0;

    case (item.mode)
      MODE_ACK: begin
        if (is_reject) begin
          status = STAT_REJECT;
        end else begin
          arrival_css_next = in_css;
          // Detector runs only in enabled slow start with matching segment size
          if (detector_enabled && !initial_done && (item.cwnd < item.ssthresh) &&
              (item.model_mss == item.link_mss)) begin
            // Close the round; flag exit once enough CSS rounds are done
            if (start_round) begin
              if (in_css && (round_end_delivered != 64'd0)) begin
                css_rounds_done_next = rounds_inc;
                if (rounds_inc >= cfg.css_round_limit) begin
                  exit_flag_next = 1'b1;
                  status         = STAT_CHANGE;
                  halted         = 1'b1;
                end
              end
              if (!halted) begin
                last_round_min_rtt_next    = current_round_min_rtt;
                current_round_min_rtt_next = ALL64;
                round_sample_count_next    = 32'd0;
                round_end_delivered_next   = sat_add(item.delivered_bytes,
                                                     item.bytes_in_flight);
              end
            end
            // Take the RTT sample and decide on the phase
            if (!halted && item.rtt_valid && (item.rtt_sample_ns != 64'd0)) begin
              cur_new = (item.rtt_sample_ns < current_round_min_rtt_next) ?
                        item.rtt_sample_ns : current_round_min_rtt_next;
              cnt_new = (round_sample_count_next == ALL32) ? round_sample_count_next :
                        round_sample_count_next + 32'd1;
              current_round_min_rtt_next = cur_new;
              round_sample_count_next    = cnt_new;
              enough = cnt_new >= {24'd0, cfg.min_rtt_samples};
              // Clamp the threshold: lower bound first, upper bound wins
              thr_raw = last_round_min_rtt_next >> RTT_DIVISOR_SHIFT;
              if (thr_raw < {32'd0, cfg.min_delay_threshold_ns}) begin
                thr_raw = {32'd0, cfg.min_delay_threshold_ns};
              end
              if (thr_raw > {32'd0, cfg.max_delay_threshold_ns}) begin
                thr = cfg.max_delay_threshold_ns;
              end else begin
                thr = thr_raw[31:0];
              end
              if (in_css) begin
                if (enough && (cur_new < css_baseline_rtt)) begin
                  in_css_next           = 1'b0;
                  css_baseline_rtt_next = ALL64;
                  css_rounds_done_next  = 8'd0;
                  revert_events_next    = revert_events + 32'd1;
                  status                = STAT_CHANGE;
                end
              end else if (enough && (last_round_min_rtt_next != ALL64) &&
                           (cur_new != ALL64) &&
                           (cur_new >= sat_add(last_round_min_rtt_next, {32'd0, thr}))) begin
                css_baseline_rtt_next = cur_new;
                in_css_next           = 1'b1;
                css_rounds_done_next  = 8'd0;
                enter_events_next     = enter_events + 32'd1;
                status                = STAT_CHANGE;
              end
            end
          end
        end
      end
      MODE_RESTART: begin
        last_round_min_rtt_next    = ALL64;
        current_round_min_rtt_next = ALL64;
        css_baseline_rtt_next      = ALL64;
        round_end_delivered_next   = 64'd0;
        round_sample_count_next    = 32'd0;
        css_rounds_done_next       = 8'd0;
        enter_events_next          = 32'd0;
        revert_events_next         = 32'd0;
        detector_enabled_next      = 1'b1;
        in_css_next                = 1'b0;
        arrival_css_next           = 1'b0;
        exit_flag_next             = 1'b0;
        initial_done_next          = 1'b0;
      end
      MODE_DISABLE: begin
        detector_enabled_next = 1'b0;
        in_css_next           = 1'b0;
        arrival_css_next      = 1'b0;
        exit_flag_next        = 1'b0;
        initial_done_next     = 1'b1;
      end
      default: ;
    endcase
  end

  // Result reflects the state after this item
  always_comb begin
    result.status           = status;
    result.ack_in_css       = arrival_css_next;
    result.css_active       = in_css_next;
    result.exit_pending     = exit_flag_next;
    result.css_round_count  = css_rounds_done_next;
    result.css_enter_count  = enter_events_next;
    result.css_revert_count = revert_events_next;
  end

  // Commit state on each stepped item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_round_min_rtt    <= ALL64;
      current_round_min_rtt <= ALL64;
      css_baseline_rtt      <= ALL64;
      round_end_delivered   <= 64'd0;
      round_sample_count    <= 32'd0;
      css_rounds_done       <= 8'd0;
      enter_events          <= 32'd0;
      revert_events         <= 32'd0;
      detector_enabled      <= 1'b1;
      in_css                <= 1'b0;
      arrival_css           <= 1'b0;
      exit_flag             <= 1'b0;
      initial_done          <= 1'b0;
    end else if (step) begin
      last_round_min_rtt    <= last_round_min_rtt_next;
      current_round_min_rtt <= current_round_min_rtt_next;
      css_baseline_rtt      <= css_baseline_rtt_next;
      round_end_delivered   <= round_end_delivered_next;
      round_sample_count    <= round_sample_count_next;
      css_rounds_done       <= css_rounds_done_next;
      enter_events          <= enter_events_next;
      revert_events         <= revert_events_next;
      detector_enabled      <= detector_enabled_next;
      in_css                <= in_css_next;
      arrival_css           <= arrival_css_next;
      exit_flag             <= exit_flag_next;
      initial_done          <= initial_done_next;
    end
  end

`ifndef SYNTHESIS
  // Enabled and disabled-latch flags always disagree
  a_enable_latch: assert property (@(posedge clk) disable iff (rst)
    detector_enabled != initial_done)
    else $error("detector_enabled and initial_done out of step");

  // CSS only runs while the detector is enabled
  a_css_enabled: assert property (@(posedge clk) disable iff (rst)
    in_css |-> detector_enabled)
    else $error("in_css set while detector disabled");

  // Exit flag only stands while the detector is enabled
  a_exit_enabled: assert property (@(posedge clk) disable iff (rst)
    exit_flag |-> detector_enabled)
    else $error("exit_flag set while detector disabled");

  // A rejected ACK leaves the phase and round tracking untouched
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    (step && (item.mode == MODE_ACK) && is_reject) |=>
      ($stable(in_css) && $stable(arrival_css) && $stable(round_end_delivered)))
    else $error("rejected ACK changed detector state");
`endif

endmodule

// File: rtl/slow_start_exit_detector.sv
// ----------------------------------------------------------------------------
// slow_start_exit_detector: HyStart++ style slow start exit detector
// Per-ACK round tracking with round minimum RTT, conservative slow start
// entry and revert, and exit flagging after the configured CSS rounds.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   s_*      | in        | s_tvalid/s_tready  | s_tuser mode, s_tdata ACK fields
//   m_*      | out       | m_tvalid/m_tready  | m_tuser status, m_tdata counters
//   cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while m_tready is high; each request passes the item register, then the result register.
// The item register feeds one pass of compare/add logic that updates the
// detector state and loads the result register in the same cycle.
// A stalled result holds the result register and then the item register;
// s_tready drops only while both are full and m_tready is low.
// rst is synchronous; it restores the state and register reset values.
// ----------------------------------------------------------------------------
module slow_start_exit_detector
  import ssed_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [1:0] mode
  input  logic [1:0]            s_tuser,
  // [63:0] delivered_bytes, [127:64] bytes_in_flight, [191:128] rtt_sample_ns,
  // [192] rtt_valid, [232:193] cwnd, [272:233] ssthresh, [288:273] link_mss,
  // [304:289] model_mss, [305] time_nonzero, [311:306] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [1:0] status
  output logic [1:0]            m_tuser,
  // [0] ack_in_css, [1] css_active, [2] exit_pending, [10:3] css_round_count,
  // [42:11] css_enter_count, [74:43] css_revert_count, [79:75] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  result_t result;
  result_t out_res;
  logic    advance;

  ssed_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Item moves on when the result register is free or being drained
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  // Item register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.mode            <= s_tuser;
      item.delivered_bytes <= s_tdata[63:0];
      item.bytes_in_flight <= s_tdata[127:64];
      item.rtt_sample_ns   <= s_tdata[191:128];
      item.rtt_valid       <= s_tdata[192];
      item.cwnd            <= s_tdata[232:193];
      item.ssthresh        <= s_tdata[272:233];
      item.link_mss        <= s_tdata[288:273];
      item.model_mss       <= s_tdata[304:289];
      item.time_nonzero    <= s_tdata[305];
    end
  end

  ssed_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = {5'd0, out_res.css_revert_count, out_res.css_enter_count,
                    out_res.css_round_count, out_res.exit_pending,
                    out_res.css_active, out_res.ack_in_css};

endmodule
